// ===== design/ppmq_pkg.sv =====
// shared types and constants for the priority message queue
package ppmq_pkg;
  localparam int QueueDepth = 8;
  localparam int SlotW = $clog2(QueueDepth);
  localparam int MaxText = 256;

  typedef enum logic [2:0] {
    KIND_PUSH = 3'd0, KIND_TICK = 3'd1, KIND_DISMISS_TAG = 3'd2,
    KIND_DISMISS_ACT = 3'd3, KIND_DISMISS_ALL = 3'd4, KIND_CLEAR = 3'd5
  } kind_e;

  localparam logic [2:0] ST_INVALID = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_SHOWN = 3'd2;
  localparam logic [2:0] ST_QUEUED = 3'd3;
  localparam logic [2:0] ST_DROPPED = 3'd4;
  localparam logic [2:0] ST_YES = 3'd5;
  localparam logic [2:0] ST_NO = 3'd6;

  typedef struct packed {
    logic        dism;
    logic        hold;
    logic [7:0]  dur;
    logic [1:0]  prio;
    logic        auto_tag;
    logic [15:0] tag;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [15:0] pay;
    logic [31:0] seq;
  } entry_t;

  function automatic logic ranks_ahead(entry_t a, entry_t b);
    if (a.meta.prio != b.meta.prio) return a.meta.prio > b.meta.prio;
    return a.seq < b.seq;
  endfunction
endpackage

// ===== design/preemptive_priority_message_queue.sv =====
// top level of the preemptive priority message queue
// One command beat is taken when start_i is high and busy_o is low; its result beat shows
// for one cycle with done_o and the receiver cannot stall it. After accept a command
// scans the slots, applies and then shows its result; a tick, or a push that queues or
// displaces an entry, passes a finish state before the result, and a dismiss all that
// removes the active entry rescans the slots before that finish state. busy_o is already
// low in the result cycle, so the next command can be accepted there. A sequencer walks
// the waiting slots one per cycle through one tag compare and two rank compares to find
// a match, the best, the worst and a free slot, then applies.
module preemptive_priority_message_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [47:0] now_ms_i,
  input  logic [15:0] id_tag_i,
  input  logic        id_given_i,
  input  logic [9:0]  text_length_i,
  input  logic [1:0]  priority_req_i,
  input  logic [7:0]  duration_s_i,
  input  logic        hold_i,
  input  logic        dismissible_i,
  input  logic [15:0] payload_handle_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  removed_count_o,
  output logic        active_valid_o,
  output logic [15:0] active_tag_o,
  output logic        active_tag_auto_o,
  output logic [1:0]  active_level_o,
  output logic [15:0] active_handle_o,
  output logic [31:0] dropped_count_o
);
  import ppmq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_SCAN2, S_FIN, S_OUT} state_e;

  state_e                state_q;
  logic [SlotW-1:0]      idx_q;
  logic [2:0]            kind_q;
  logic [47:0]           now_q, start_q;
  logic [16:0]           id_q;
  entry_t                new_q, act_q;
  logic                  act_v_q;
  logic                  len_ok_q;
  logic [QueueDepth-1:0] sv_q;
  entry_t                slot_q [QueueDepth];
  logic [31:0]           nseq_q, drop_q;
  logic                  mf_q, bf_q, wf_q, ff_q;
  logic [SlotW-1:0]      mi_q, bi_q, wi_q, fi_q;
  logic [2:0]            st_q;
  logic [3:0]            rem_q;
  logic                  pend_q;
  entry_t                pend_e_q;
  logic                  bp_q;
  logic [16:0]           bid_q;

  logic [SlotW-1:0] ix;
  entry_t           cur;
  logic             cur_v;
  logic [47:0]      elapsed;
  logic [17:0]      dur_ms;

  assign ix = idx_q;
  assign cur = slot_q[ix];
  assign cur_v = sv_q[ix];
  assign elapsed = (now_ms_i < start_q) ? 48'd0 : now_ms_i - start_q;
  assign dur_ms = 18'(act_q.meta.dur) * 18'd1000;
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      act_v_q <= 1'b0;
      sv_q <= '0;
      nseq_q <= '0;
      drop_q <= '0;
      done_o <= 1'b0;
      pend_q <= 1'b0;
      act_q <= '0;
      start_q <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: if (start_i) begin
          kind_q <= kind_i;
          now_q <= now_ms_i;
          id_q <= {~id_given_i,
                   (kind_i == KIND_PUSH && !id_given_i) ? nseq_q[15:0] : id_tag_i};
          len_ok_q <= (text_length_i != 10'd0) && (text_length_i <= 10'(MaxText));
          new_q.meta <= {dismissible_i, hold_i,
                         (duration_s_i == 8'd0) ? 8'd1 : duration_s_i,
                         priority_req_i, ~id_given_i, id_given_i ? id_tag_i : nseq_q[15:0]};
          new_q.pay <= payload_handle_i;
          new_q.seq <= nseq_q;
          if (kind_i == KIND_DISMISS_ACT) id_q <= {act_q.meta.auto_tag, act_q.meta.tag};
          bp_q <= act_v_q;
          bid_q <= act_v_q ? {act_q.meta.auto_tag, act_q.meta.tag} : 17'd0;
          rem_q <= '0;
          st_q <= ST_NO;
          pend_q <= 1'b0;
          {mf_q, bf_q, wf_q, ff_q} <= '0;
          idx_q <= '0;
          state_q <= S_SCAN;
          // tick expiry decided up front
          if (kind_i == KIND_TICK && act_v_q && !act_q.meta.hold) begin
            if (elapsed >= 48'(dur_ms))
              act_v_q <= 1'b0;
          end
        end
        S_SCAN, S_SCAN2: begin
          if (cur_v) begin
            if (!mf_q && {cur.meta.auto_tag, cur.meta.tag} == id_q) begin
              mf_q <= 1'b1; mi_q <= ix;
            end
            if (!bf_q || ranks_ahead(cur, slot_q[bi_q])) begin
              bf_q <= 1'b1; bi_q <= ix;
            end
            if (!wf_q || ranks_ahead(slot_q[wi_q], cur)) begin
              wf_q <= 1'b1; wi_q <= ix;
            end
            if (kind_q == KIND_DISMISS_ALL && state_q == S_SCAN && cur.meta.dism) begin
              sv_q[ix] <= 1'b0;
              rem_q <= rem_q + 4'd1;
            end
          end else if (!ff_q) begin
            ff_q <= 1'b1; fi_q <= ix;
          end
          if (idx_q == SlotW'(QueueDepth - 1)) begin
            state_q <= (state_q == S_SCAN) ? S_APPLY : S_FIN;
            idx_q <= '0;
          end else idx_q <= idx_q + SlotW'(1);
        end
        S_APPLY: begin
          state_q <= S_OUT;
          case (kind_q)
            KIND_PUSH: begin
              if (!len_ok_q) st_q <= ST_INVALID;
              else if (act_v_q && {act_q.meta.auto_tag, act_q.meta.tag} == id_q) begin
                act_q.meta <= new_q.meta; act_q.pay <= new_q.pay; start_q <= now_q;
                st_q <= ST_REPLACED;
              end else if (mf_q) begin
                slot_q[mi_q].meta <= new_q.meta; slot_q[mi_q].pay <= new_q.pay;
                st_q <= ST_REPLACED;
              end else begin
                nseq_q <= nseq_q + 32'd1;
                if (!act_v_q) begin
                  act_v_q <= 1'b1; act_q <= new_q; start_q <= now_q; st_q <= ST_SHOWN;
                end else if (new_q.meta.prio > act_q.meta.prio) begin
                  act_q <= new_q; start_q <= now_q; st_q <= ST_SHOWN;
                  pend_q <= 1'b1; pend_e_q <= act_q; state_q <= S_FIN;
                end else begin
                  pend_q <= 1'b1; pend_e_q <= new_q; state_q <= S_FIN;
                end
              end
            end
            KIND_TICK: begin
              if (!act_v_q) begin
                if (bf_q) begin
                  act_q <= slot_q[bi_q]; act_v_q <= 1'b1; start_q <= now_q;
                  sv_q[bi_q] <= 1'b0;
                end
              end else if (bf_q && slot_q[bi_q].meta.prio > act_q.meta.prio) begin
                act_q <= slot_q[bi_q]; start_q <= now_q; slot_q[bi_q] <= act_q;
              end
              state_q <= S_FIN;
            end
            KIND_DISMISS_TAG, KIND_DISMISS_ACT: begin
              if (kind_q == KIND_DISMISS_ACT && !act_v_q) st_q <= ST_NO;
              else if (act_v_q && {act_q.meta.auto_tag, act_q.meta.tag} == id_q) begin
                if (act_q.meta.dism) begin
                  st_q <= ST_YES; act_v_q <= 1'b0;
                  if (bf_q) begin
                    act_q <= slot_q[bi_q]; act_v_q <= 1'b1; start_q <= now_q;
                    sv_q[bi_q] <= 1'b0;
                  end
                end
              end else if (mf_q && slot_q[mi_q].meta.dism) begin
                sv_q[mi_q] <= 1'b0; st_q <= ST_YES;
              end
            end
            KIND_DISMISS_ALL: begin
              // rescan needed for best among the survivors
              if (act_v_q && act_q.meta.dism) begin
                act_v_q <= 1'b0;
                rem_q <= (rem_q == 4'd15) ? rem_q : rem_q + 4'd1;
                {bf_q, wf_q, mf_q, ff_q} <= '0;
                pend_q <= 1'b1;
                state_q <= S_SCAN2;
              end else st_q <= (rem_q != 4'd0) ? ST_YES : ST_NO;
            end
            KIND_CLEAR: begin
              sv_q <= '0; act_v_q <= 1'b0; drop_q <= '0; st_q <= ST_YES;
            end
            default: st_q <= ST_NO;
          endcase
        end
        S_FIN: begin
          state_q <= S_OUT;
          if (kind_q == KIND_TICK)
            st_q <= (bp_q != act_v_q ||
                     bid_q != (act_v_q ? {act_q.meta.auto_tag, act_q.meta.tag} : 17'd0))
                    ? ST_YES : ST_NO;
          else if (kind_q == KIND_DISMISS_ALL) begin
            st_q <= ST_YES;
            if (bf_q) begin
              act_q <= slot_q[bi_q]; act_v_q <= 1'b1; start_q <= now_q;
              sv_q[bi_q] <= 1'b0;
            end
          end else if (pend_q) begin
            if (ff_q) begin
              slot_q[fi_q] <= pend_e_q; sv_q[fi_q] <= 1'b1;
              if (st_q != ST_SHOWN) st_q <= ST_QUEUED;
            end else begin
              if (drop_q != 32'hFFFF_FFFF) drop_q <= drop_q + 32'd1;
              if (wf_q && ranks_ahead(pend_e_q, slot_q[wi_q])) begin
                slot_q[wi_q] <= pend_e_q;
                if (st_q != ST_SHOWN) st_q <= ST_QUEUED;
              end else if (st_q != ST_SHOWN) st_q <= ST_DROPPED;
            end
          end
        end
        S_OUT: begin
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    status_o = st_q;
    removed_count_o = (kind_q == KIND_DISMISS_ALL) ? rem_q : 4'd0;
    active_valid_o = act_v_q;
    active_tag_o = act_v_q ? act_q.meta.tag : 16'd0;
    active_tag_auto_o = act_v_q ? act_q.meta.auto_tag : 1'b0;
    active_level_o = act_v_q ? act_q.meta.prio : 2'd0;
    active_handle_o = act_v_q ? act_q.pay : 16'd0;
    dropped_count_o = drop_q;
  end

  a_done_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> done_o && state_q == S_IDLE) else $error("done missing");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_drop_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(kind_q) != KIND_CLEAR && $past(state_q) != S_IDLE |-> drop_q >= $past(drop_q))
    else $error("drop count fell");
endmodule

// ===== bench/preemptive_priority_message_queue_test.sv =====
// testbench for the preemptive priority message queue: directed table, then random commands
module preemptive_priority_message_queue_test;
  import ppmq_pkg::*;

  localparam int IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  kind_i = '0;
  logic [47:0] now_ms_i = '0;
  logic [15:0] id_tag_i = '0;
  logic        id_given_i = 1'b0;
  logic [9:0]  text_length_i = '0;
  logic [1:0]  priority_req_i = '0;
  logic [7:0]  duration_s_i = '0;
  logic        hold_i = 1'b0;
  logic        dismissible_i = 1'b0;
  logic [15:0] payload_handle_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [3:0]  removed_count_o;
  logic        active_valid_o;
  logic [15:0] active_tag_o;
  logic        active_tag_auto_o;
  logic [1:0]  active_level_o;
  logic [15:0] active_handle_o;
  logic [31:0] dropped_count_o;

  preemptive_priority_message_queue DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] now;
    logic [15:0] tag;
    logic        given;
    logic [9:0]  len;
    logic [1:0]  prio;
    logic [7:0]  dur;
    logic        hold;
    logic        dism;
    logic [15:0] pay;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  removed;
    logic        av;
    logic [15:0] atag;
    logic        aauto;
    logic [1:0]  alevel;
    logic [15:0] ahandle;
    logic [31:0] dropped;
  } res_t;

  // model state
  logic        act_on;
  meta_t       act_meta;
  logic [15:0] act_pay;
  logic [31:0] act_seq;
  logic [47:0] act_start;
  logic        q_on [QueueDepth];
  meta_t       q_meta [QueueDepth];
  logic [15:0] q_pay [QueueDepth];
  logic [31:0] q_seq [QueueDepth];
  logic [31:0] seq_next;
  logic [31:0] drop_total;

  res_t outcome_q[$];
  int   errors = 0;
  int   accepted = 0;
  int   results = 0;
  int   idle = 0;
  int   kind_seen [8];

  function automatic logic ahead(meta_t ma, logic [31:0] sa, meta_t mb, logic [31:0] sb);
    if (ma.prio != mb.prio) return ma.prio > mb.prio;
    return sa < sb;
  endfunction

  function automatic int best_idx();
    int b;
    b = -1;
    for (int i = 0; i < QueueDepth; i++)
      if (q_on[i] && (b < 0 || ahead(q_meta[i], q_seq[i], q_meta[b], q_seq[b]))) b = i;
    return b;
  endfunction

  function automatic int worst_idx();
    int w;
    w = -1;
    for (int i = 0; i < QueueDepth; i++)
      if (q_on[i] && (w < 0 || ahead(q_meta[w], q_seq[w], q_meta[i], q_seq[i]))) w = i;
    return w;
  endfunction

  function automatic void bump_drop();
    if (drop_total != 32'hFFFF_FFFF) drop_total++;
  endfunction

  function automatic logic park(meta_t m, logic [15:0] p, logic [31:0] s);
    int w;
    for (int i = 0; i < QueueDepth; i++)
      if (!q_on[i]) begin
        q_on[i] = 1; q_meta[i] = m; q_pay[i] = p; q_seq[i] = s;
        return 1;
      end
    w = worst_idx();
    bump_drop();
    if (w < 0 || !ahead(m, s, q_meta[w], q_seq[w])) return 0;
    q_meta[w] = m; q_pay[w] = p; q_seq[w] = s;
    return 1;
  endfunction

  function automatic void raise(int i, logic [47:0] now);
    act_meta = q_meta[i]; act_pay = q_pay[i]; act_seq = q_seq[i];
    act_start = now; act_on = 1; q_on[i] = 0;
  endfunction

  function automatic void raise_best(logic [47:0] now);
    int b;
    b = best_idx();
    if (b >= 0) raise(b, now);
  endfunction

  function automatic logic same_id(meta_t a, logic [16:0] id);
    return {a.auto_tag, a.tag} == id;
  endfunction

  function automatic logic [2:0] drop_by_id(logic [16:0] id, logic [47:0] now);
    if (act_on && same_id(act_meta, id)) begin
      if (!act_meta.dism) return ST_NO;
      act_on = 0;
      raise_best(now);
      return ST_YES;
    end
    for (int i = 0; i < QueueDepth; i++)
      if (q_on[i] && same_id(q_meta[i], id)) begin
        if (!q_meta[i].dism) return ST_NO;
        q_on[i] = 0;
        return ST_YES;
      end
    return ST_NO;
  endfunction

  function automatic res_t queue_outcome(cmd_t c);
    res_t r;
    meta_t m, dm;
    logic [16:0] id;
    logic [31:0] s, ds;
    logic [15:0] dp;
    logic bp;
    logic [16:0] bid, aid;
    logic [47:0] el;
    logic matched;
    int b, n;
    r = '0;
    r.status = ST_NO;
    n = 0;
    case (c.kind)
      KIND_PUSH: begin
        if (c.len == 0 || c.len > MaxText) r.status = ST_INVALID;
        else begin
          id = c.given ? {1'b0, c.tag} : {1'b1, seq_next[15:0]};
          m.tag = id[15:0]; m.auto_tag = id[16]; m.prio = c.prio;
          m.dur = (c.dur == 0) ? 8'd1 : c.dur; m.hold = c.hold; m.dism = c.dism;
          matched = 1'b0;
          if (act_on && same_id(act_meta, id)) begin
            act_meta = m; act_pay = c.pay; act_start = c.now; r.status = ST_REPLACED;
            matched = 1'b1;
          end else begin
            for (int i = 0; i < QueueDepth; i++)
              if (!matched && q_on[i] && same_id(q_meta[i], id)) begin
                q_meta[i] = m; q_pay[i] = c.pay; r.status = ST_REPLACED;
                matched = 1'b1;
              end
          end
          if (!matched) begin
            s = seq_next;
            seq_next++;
            if (!act_on) begin
              act_on = 1; act_meta = m; act_pay = c.pay; act_seq = s; act_start = c.now;
              r.status = ST_SHOWN;
            end else if (m.prio > act_meta.prio) begin
              dm = act_meta; dp = act_pay; ds = act_seq;
              act_meta = m; act_pay = c.pay; act_seq = s; act_start = c.now;
              void'(park(dm, dp, ds));
              r.status = ST_SHOWN;
            end else r.status = park(m, c.pay, s) ? ST_QUEUED : ST_DROPPED;
          end
        end
      end
      KIND_TICK: begin
        bp = act_on;
        bid = act_on ? {act_meta.auto_tag, act_meta.tag} : '0;
        if (act_on && !act_meta.hold) begin
          el = (c.now < act_start) ? '0 : c.now - act_start;
          if ({16'd0, el} >= 64'(act_meta.dur) * 1000) act_on = 0;
        end
        if (!act_on) raise_best(c.now);
        else begin
          b = best_idx();
          if (b >= 0 && q_meta[b].prio > act_meta.prio) begin
            dm = act_meta; dp = act_pay; ds = act_seq;
            raise(b, c.now);
            q_on[b] = 1; q_meta[b] = dm; q_pay[b] = dp; q_seq[b] = ds;
          end
        end
        aid = act_on ? {act_meta.auto_tag, act_meta.tag} : '0;
        r.status = (bp != act_on || bid != aid) ? ST_YES : ST_NO;
      end
      KIND_DISMISS_TAG: r.status = drop_by_id({~c.given, c.tag}, c.now);
      KIND_DISMISS_ACT:
        r.status = act_on ? drop_by_id({act_meta.auto_tag, act_meta.tag}, c.now) : ST_NO;
      KIND_DISMISS_ALL: begin
        for (int i = 0; i < QueueDepth; i++)
          if (q_on[i] && q_meta[i].dism) begin
            q_on[i] = 0; n++;
          end
        if (act_on && act_meta.dism) begin
          act_on = 0; n++; raise_best(c.now);
        end
        r.status = n ? ST_YES : ST_NO;
        r.removed = (n > 15) ? 4'd15 : 4'(n);
      end
      KIND_CLEAR: begin
        for (int i = 0; i < QueueDepth; i++) q_on[i] = 0;
        act_on = 0; drop_total = 0; r.status = ST_YES;
      end
      default: ;
    endcase
    r.av = act_on;
    r.atag = act_on ? act_meta.tag : '0;
    r.aauto = act_on ? act_meta.auto_tag : 1'b0;
    r.alevel = act_on ? act_meta.prio : '0;
    r.ahandle = act_on ? act_pay : '0;
    r.dropped = drop_total;
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (done_o) begin
      results++;
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = outcome_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (removed_count_o !== e.removed) begin
          $error("removed_count exp %0d got %0d", e.removed, removed_count_o); errors++;
        end
        if (active_valid_o !== e.av) begin
          $error("active_valid exp %0d got %0d", e.av, active_valid_o); errors++;
        end
        if (active_tag_o !== e.atag) begin
          $error("active_tag exp %0h got %0h", e.atag, active_tag_o); errors++;
        end
        if (active_tag_auto_o !== e.aauto) begin
          $error("active_tag_auto exp %0d got %0d", e.aauto, active_tag_auto_o); errors++;
        end
        if (active_level_o !== e.alevel) begin
          $error("active_level exp %0d got %0d", e.alevel, active_level_o); errors++;
        end
        if (active_handle_o !== e.ahandle) begin
          $error("active_handle exp %0h got %0h", e.ahandle, active_handle_o); errors++;
        end
        if (dropped_count_o !== e.dropped) begin
          $error("dropped_count exp %0d got %0d", e.dropped, dropped_count_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle <= 0;
    else idle <= idle + 1;
    if (idle >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  logic [47:0] clock_ms = '0;

  task automatic send(cmd_t c, logic check_direct, res_t want);
    res_t p;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= c.kind; now_ms_i <= c.now; id_tag_i <= c.tag; id_given_i <= c.given;
    text_length_i <= c.len; priority_req_i <= c.prio; duration_s_i <= c.dur;
    hold_i <= c.hold; dismissible_i <= c.dism; payload_handle_i <= c.pay;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = queue_outcome(c);
    if (check_direct && p != want) begin
      $error("directed row disagrees: exp %0h model %0h", want, p);
      errors++;
    end
    outcome_q = {outcome_q, p};
    accepted++;
    kind_seen[c.kind]++;
  endtask

  function automatic cmd_t mk(logic [2:0] k, logic [47:0] now, logic [15:0] tag, logic g,
                              logic [9:0] len, logic [1:0] pr, logic [7:0] dur, logic h,
                              logic d, logic [15:0] pay);
    cmd_t c;
    c.kind = k; c.now = now; c.tag = tag; c.given = g; c.len = len; c.prio = pr;
    c.dur = dur; c.hold = h; c.dism = d; c.pay = pay;
    return c;
  endfunction

  function automatic res_t rs(logic [2:0] st, logic [31:0] dr);
    res_t r;
    r = '0; r.status = st; r.dropped = dr;
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c = '0;
    r = $urandom_range(0, 99);
    c.kind = r < 50 ? KIND_PUSH : r < 75 ? KIND_TICK : r < 85 ? KIND_DISMISS_TAG :
             r < 91 ? KIND_DISMISS_ACT : r < 95 ? KIND_DISMISS_ALL : r < 98 ? KIND_CLEAR :
             3'($urandom_range(6, 7));
    clock_ms = clock_ms + 48'($urandom_range(0, 4000));
    c.now = $urandom_range(0, 30) == 0 ? 48'({$urandom, $urandom}) : clock_ms;
    c.tag = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 11));
    c.given = $urandom_range(0, 3) != 0;
    r = $urandom_range(0, 19);
    c.len = r == 0 ? 10'd0 : r == 1 ? 10'($urandom) : r == 2 ? 10'd256 :
            10'($urandom_range(1, 256));
    c.prio = 2'($urandom);
    c.dur = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 4));
    c.hold = $urandom_range(0, 5) == 0;
    c.dism = $urandom_range(0, 4) != 0;
    c.pay = 16'($urandom);
    return c;
  endfunction

  cmd_t dir_cmd [$];
  res_t dir_res [$];
  logic dir_chk [$];

  function automatic void add_row(cmd_t c, res_t r, logic chk);
    dir_cmd = {dir_cmd, c};
    dir_res = {dir_res, r};
    dir_chk = {dir_chk, chk};
  endfunction

  initial begin
    cmd_t c;
    act_on = 0; act_meta = '0; act_pay = '0; act_seq = '0; act_start = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      q_on[i] = 0; q_meta[i] = '0; q_pay[i] = '0; q_seq[i] = '0;
    end
    seq_next = '0; drop_total = '0;
    for (int i = 0; i < 8; i++) kind_seen[i] = 0;

    add_row(mk(KIND_TICK, '0, '0, 0, 0, 0, 0, 0, 0, '0), rs(ST_NO, 0), 1);
    add_row(mk(KIND_PUSH, '0, 16'hFFFF, 1, 10'd0, 3, 8'd5, 0, 1, 16'hFFFF),
            rs(ST_INVALID, 0), 1);
    add_row(mk(KIND_PUSH, '0, 16'hFFFF, 1, 10'd257, 3, 8'd5, 0, 1, 16'hFFFF),
            rs(ST_INVALID, 0), 1);
    add_row(mk(KIND_PUSH, '0, 16'hFFFF, 1, 10'h3FF, 3, 8'd5, 0, 1, 16'hFFFF),
            rs(ST_INVALID, 0), 1);
    add_row(mk(KIND_DISMISS_ACT, '0, '0, 0, 0, 0, 0, 0, 0, '0), rs(ST_NO, 0), 1);
    add_row(mk(KIND_DISMISS_ALL, '0, '0, 0, 0, 0, 0, 0, 0, '0), rs(ST_NO, 0), 1);
    add_row(mk(3'd6, '0, '0, 0, 0, 0, 0, 0, 0, '0), rs(ST_NO, 0), 1);
    add_row(mk(3'd7, '1, '1, 1, '1, 3, '1, 1, 1, '1), rs(ST_NO, 0), 1);
    // auto tag, zero duration
    add_row(mk(KIND_PUSH, 48'd100, '0, 0, 10'd1, 0, 8'd0, 0, 1, 16'h1234), '0, 0);
    // fill queue at low priority, then overflow and evict
    for (int i = 0; i < 10; i++)
      add_row(mk(KIND_PUSH, 48'd200, 16'(i + 1), 1, 10'd256, 2'(i > 8 ? 1 : 0),
                 8'd255, i == 3, i != 4, 16'(i)), '0, 0);
    // preempt into a full queue, replace by tag, dismiss non dismissible
    add_row(mk(KIND_PUSH, 48'd300, 16'hFFFF, 1, 10'd8, 3, 8'd255, 1, 0, 16'hBEEF), '0, 0);
    add_row(mk(KIND_PUSH, 48'd301, 16'd2, 1, 10'd8, 2, 8'd1, 0, 1, 16'hAAAA), '0, 0);
    add_row(mk(KIND_DISMISS_TAG, 48'd302, 16'hFFFF, 1, 0, 0, 0, 0, 0, '0), '0, 0);
    add_row(mk(KIND_DISMISS_TAG, 48'd302, 16'd0, 0, 0, 0, 0, 0, 0, '0), '0, 0);
    // time going backwards, then far forward
    add_row(mk(KIND_TICK, 48'd0, '0, 0, 0, 0, 0, 0, 0, '0), '0, 0);
    add_row(mk(KIND_TICK, '1, '0, 0, 0, 0, 0, 0, 0, '0), '0, 0);
    add_row(mk(KIND_DISMISS_ALL, '1, '0, 0, 0, 0, 0, 0, 0, '0), '0, 0);
    add_row(mk(KIND_CLEAR, '0, '0, 0, 0, 0, 0, 0, 0, '0), rs(ST_YES, 0), 1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_cmd.size(); i++) send(dir_cmd[i], dir_chk[i], dir_res[i]);

    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        start_i <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk_i);
      end
      c = rand_cmd();
      send(c, 0, '0);
    end

    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("ran %0d commands: push %0d tick %0d dismiss %0d/%0d/%0d clear %0d, %0d results",
             accepted, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], results);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
